// ===== rtl/scba_pkg.sv =====
// Shared types, constants and codes for the size-class block allocator.
package scba_pkg;

   localparam int NUM_CLASSES    = 23;
   localparam int MIN_CLASS_LOG2 = 7;
   localparam int MAX_BLOCKS     = 4096;

   localparam int IDX_W  = $clog2(MAX_BLOCKS);
   localparam int CNT_W  = IDX_W + 1;
   localparam int CLS_W  = 5;
   localparam int CLSI_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

   localparam logic [31:0] SIG_WORD  = 32'h4D454D4F;
   localparam logic [31:0] HDR_BYTES = 32'd32;

   typedef enum logic [1:0] {
      CMD_MALLOC  = 2'd0,
      CMD_FREE    = 2'd1,
      CMD_REALLOC = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_NOMEM  = 2'd1,
      ST_BADSIG = 2'd2,
      ST_BADPTR = 2'd3
   } status_type;

   localparam logic [1:0] CSR_HEAP_BASE  = 2'd0;
   localparam logic [1:0] CSR_HEAP_LIMIT = 2'd1;
   localparam logic [1:0] CSR_PAGE_SHIFT = 2'd2;

   // One entry of the block store: list link and block address.
   typedef struct packed {
      logic             link_ok;
      logic [IDX_W-1:0] link;
      logic [31:0]      addr;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// ===== rtl/scba_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
module scba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/size_class_block_allocator.sv =====
// Top level of the size-class block allocator: sequencer, list heads and block store.
// How long an item takes depends on the data, set by the walk of the block store:
// malloc steps over the size classes one at a time and, on a refill, carves blocks
// one at a time (chunk size over class size); free visits the used-list entries one
// at a time. A growing realloc does the walk twice with a malloc in between. The
// block returns to idle between items, and a finished result also waits while the
// output register is still held.
// All list links and block addresses lie in one RAM of MAX_BLOCKS entries with
// a single read and a single write port, one access of each per cycle; the
// per-class list heads are flip-flops with valid bits. The result word waits in
// an output register while the next request word can be taken.
module size_class_block_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_req_size,
   input  logic [31:0] req_user_ptr,
   input  logic [31:0] req_hdr_sig,
   input  logic [4:0]  req_hdr_class,
   input  logic [31:0] req_hdr_size,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_result_ptr,
   output logic        rsp_header_write,
   output logic [4:0]  rsp_header_class,
   output logic [31:0] rsp_header_size,
   output logic [31:0] rsp_copy_src,
   output logic [31:0] rsp_copy_length,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import scba_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_MSEARCH, S_CARVE, S_POP, S_POPW,
      S_WALK, S_WALKW, S_UNLINK, S_UNLINKW, S_RESULT
   } state_type;

   state_type        state_ff;
   logic [31:0]      heap_base_ff, heap_limit_ff;
   logic [4:0]       page_shift_ff;
   logic [31:0]      break_ff;
   logic [CNT_W-1:0] taken_ff;
   logic [IDX_W-1:0] free_head_ff [NUM_CLASSES];
   logic             free_ok_ff   [NUM_CLASSES];
   logic [IDX_W-1:0] used_head_ff [NUM_CLASSES];
   logic             used_ok_ff   [NUM_CLASSES];

   // Latched request word.
   logic [1:0]  cmd_ff;
   logic [31:0] size_ff, ptr_ff, hsize_ff;
   logic [4:0]  hcls_ff;
   logic        sig_ok_ff;
   // Working registers.
   logic [CLSI_W-1:0] cls_ff;
   logic [31:0]       need_ff, bsize_ff, caddr_ff, ccnt_ff;
   logic [IDX_W-1:0]  cur_ff, prev_ff;
   logic              prev_ok_ff, release_ff, grow_ff;
   entry_type         cur_e_ff;
   // The found entry joins the free list in the cycle after unlinking.
   logic             fpush_ff;
   logic [IDX_W-1:0] fpush_idx_ff;
   entry_type        fpush_e_ff;
   // Result word being built.
   logic        rv_ff;
   logic [1:0]  r_status_ff;
   logic [31:0] r_ptr_ff, r_hsize_ff, r_src_ff, r_len_ff;
   logic        r_hw_ff;
   logic [4:0]  r_hcls_ff;
   // Output register.
   logic [1:0]  o_status_ff;
   logic [31:0] o_ptr_ff, o_hsize_ff, o_src_ff, o_len_ff;
   logic        o_hw_ff;
   logic [4:0]  o_hcls_ff;
   logic        res_load;

   // Block store.
   logic             we;
   logic [IDX_W-1:0] wa, ra;
   entry_type        wd, rd;
   logic [ENTRY_W-1:0] rd_raw;

   scba_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BLOCKS)) u_store (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wd),
      .rd_addr(ra), .rd_data(rd_raw)
   );
   assign rd = entry_type'(rd_raw);

   // A finished result moves to the output register once that is free and the free-list push is done.
   assign res_load = (state_ff == S_RESULT) && !fpush_ff && (!rv_ff || !rsp_stall);

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_status = o_status_ff;
   assign rsp_result_ptr = o_ptr_ff;
   assign rsp_header_write = o_hw_ff;
   assign rsp_header_class = o_hcls_ff;
   assign rsp_header_size = o_hsize_ff;
   assign rsp_copy_src = o_src_ff;
   assign rsp_copy_length = o_len_ff;

   // Refill checks for the current class, header class index and block address.
   logic [32:0] pmask, chunk, brk_end;
   logic [CNT_W+32:0] cnt_sum;
   logic [31:0] cnt;
   logic [4:0]  hcls_idx_raw;
   logic [CLSI_W-1:0] hidx;
   logic [31:0] blk_addr;
   always_comb begin
      pmask   = (33'd1 << page_shift_ff) - 33'd1;
      chunk   = ({1'b0, bsize_ff} + pmask) & ~pmask;
      cnt     = 32'(chunk >> (MIN_CLASS_LOG2 + 32'(cls_ff)));
      brk_end = {1'b0, break_ff} + chunk;
      cnt_sum = (CNT_W+33)'(taken_ff) + (CNT_W+33)'(cnt);
      hcls_idx_raw = hcls_ff;
      hidx = CLSI_W'(hcls_idx_raw);
      blk_addr = ptr_ff - HDR_BYTES;
   end

   // Store port selection, one read and one write per cycle.
   always_comb begin
      we = 1'b0;
      wa = '0;
      wd = '0;
      ra = cur_ff;
      unique case (state_ff)
         S_CARVE: begin
            we = 1'b1;
            wa = taken_ff[IDX_W-1:0];
            wd.addr = caddr_ff;
            wd.link = free_head_ff[cls_ff];
            wd.link_ok = free_ok_ff[cls_ff];
         end
         S_POPW: begin
            we = 1'b1;
            wa = cur_ff;
            wd.addr = rd.addr;
            wd.link = used_head_ff[cls_ff];
            wd.link_ok = used_ok_ff[cls_ff];
         end
         S_UNLINK: begin
            ra = prev_ff;
         end
         S_UNLINKW: begin
            // Previous entry takes the found entry's link.
            if (prev_ok_ff) begin
               we = 1'b1;
               wa = prev_ff;
               wd.addr = rd.addr;
               wd.link = cur_e_ff.link;
               wd.link_ok = cur_e_ff.link_ok;
            end
         end
         S_RESULT: begin
            // Released block is re-linked onto its free list.
            if (fpush_ff) begin
               we = 1'b1;
               wa = fpush_idx_ff;
               wd = fpush_e_ff;
            end
         end
         default: ;
      endcase
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         heap_base_ff <= 32'h1000_0000;
         heap_limit_ff <= 32'h2000_0000;
         page_shift_ff <= 5'd12;
         break_ff <= 32'h1000_0000;
         taken_ff <= '0;
         rv_ff <= 1'b0;
         fpush_ff <= 1'b0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            free_ok_ff[i] <= 1'b0;
            used_ok_ff[i] <= 1'b0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_HEAP_BASE: begin
                  heap_base_ff <= csr_data;
                  if (taken_ff == '0) begin
                     break_ff <= csr_data;
                  end
               end
               CSR_HEAP_LIMIT: heap_limit_ff <= csr_data;
               CSR_PAGE_SHIFT: page_shift_ff <= csr_data[4:0];
               default: ;
            endcase
         end
         // Output register: loaded with a finished result, emptied when taken.
         if (res_load) begin
            rv_ff <= 1'b1;
            o_status_ff <= r_status_ff;
            o_ptr_ff <= r_ptr_ff;
            o_hw_ff <= r_hw_ff;
            o_hcls_ff <= r_hcls_ff;
            o_hsize_ff <= r_hsize_ff;
            o_src_ff <= r_src_ff;
            o_len_ff <= r_len_ff;
         end else if (rv_ff && !rsp_stall) begin
            rv_ff <= 1'b0;
         end
         fpush_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && !req_stall) begin
                  cmd_ff <= req_cmd;
                  size_ff <= req_req_size;
                  ptr_ff <= req_user_ptr;
                  sig_ok_ff <= (req_hdr_sig == SIG_WORD);
                  hcls_ff <= req_hdr_class;
                  hsize_ff <= req_hdr_size;
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               r_status_ff <= ST_OK;
               r_ptr_ff <= '0;
               r_hw_ff <= 1'b0;
               r_hcls_ff <= '0;
               r_hsize_ff <= '0;
               r_src_ff <= '0;
               r_len_ff <= '0;
               cls_ff <= '0;
               bsize_ff <= 32'd1 << MIN_CLASS_LOG2;
               need_ff <= 32'((({32'd0, size_ff} + 64'd71) & ~64'd7) > 64'hFFFF_FFFF ?
                          32'hFFFF_FFFF : (({32'd0, size_ff} + 64'd71) & ~64'd7));
               grow_ff <= 1'b0;
               prev_ok_ff <= 1'b0;
               unique case (cmd_type'(cmd_ff))
                  CMD_MALLOC: state_ff <= S_MSEARCH;
                  CMD_FREE: begin
                     if (ptr_ff == '0) begin
                        state_ff <= S_RESULT;
                     end else if (!sig_ok_ff) begin
                        r_status_ff <= ST_BADSIG;
                        state_ff <= S_RESULT;
                     end else if (32'(hcls_ff) >= NUM_CLASSES || !used_ok_ff[hidx]) begin
                        r_status_ff <= ST_BADPTR;
                        state_ff <= S_RESULT;
                     end else begin
                        release_ff <= 1'b1;
                        cur_ff <= used_head_ff[hidx];
                        state_ff <= S_WALK;
                     end
                  end
                  CMD_REALLOC: begin
                     if (ptr_ff == '0) begin
                        state_ff <= S_MSEARCH;
                     end else if (!sig_ok_ff) begin
                        r_status_ff <= ST_BADSIG;
                        state_ff <= S_RESULT;
                     end else if (size_ff <= hsize_ff) begin
                        r_ptr_ff <= ptr_ff;
                        r_hw_ff <= 1'b1;
                        r_hcls_ff <= hcls_ff;
                        r_hsize_ff <= size_ff;
                        state_ff <= S_RESULT;
                     end else if (32'(hcls_ff) >= NUM_CLASSES || !used_ok_ff[hidx]) begin
                        r_status_ff <= ST_BADPTR;
                        state_ff <= S_RESULT;
                     end else begin
                        grow_ff <= 1'b1;
                        release_ff <= 1'b0;
                        cur_ff <= used_head_ff[hidx];
                        state_ff <= S_WALK;
                     end
                  end
                  default: state_ff <= S_RESULT;
               endcase
            end
            // Smallest fitting class, one class a cycle.
            S_MSEARCH: begin
               if (need_ff <= bsize_ff && need_ff != 32'hFFFF_FFFF) begin
                  if (free_ok_ff[cls_ff]) begin
                     cur_ff <= free_head_ff[cls_ff];
                     state_ff <= S_POP;
                  end else if (brk_end > {1'b0, heap_limit_ff} ||
                               cnt_sum > (CNT_W+33)'(MAX_BLOCKS)) begin
                     r_status_ff <= ST_NOMEM;
                     state_ff <= S_RESULT;
                  end else begin
                     caddr_ff <= break_ff;
                     ccnt_ff <= cnt;
                     break_ff <= 32'(brk_end);
                     state_ff <= S_CARVE;
                  end
               end else if (32'(cls_ff) == NUM_CLASSES - 1) begin
                  r_status_ff <= ST_NOMEM;
                  state_ff <= S_RESULT;
               end else begin
                  cls_ff <= cls_ff + 1'b1;
                  bsize_ff <= bsize_ff << 1;
               end
            end
            // One carved block pushed per cycle.
            S_CARVE: begin
               free_head_ff[cls_ff] <= taken_ff[IDX_W-1:0];
               free_ok_ff[cls_ff] <= 1'b1;
               taken_ff <= taken_ff + 1'b1;
               caddr_ff <= caddr_ff + bsize_ff;
               ccnt_ff <= ccnt_ff - 32'd1;
               if (ccnt_ff == 32'd1) begin
                  cur_ff <= taken_ff[IDX_W-1:0];
                  state_ff <= S_POP;
               end
            end
            S_POP: state_ff <= S_POPW;
            S_POPW: begin
               free_head_ff[cls_ff] <= rd.link;
               free_ok_ff[cls_ff] <= rd.link_ok;
               used_head_ff[cls_ff] <= cur_ff;
               used_ok_ff[cls_ff] <= 1'b1;
               r_status_ff <= ST_OK;
               r_ptr_ff <= rd.addr + HDR_BYTES;
               r_hw_ff <= 1'b1;
               r_hcls_ff <= 5'(cls_ff);
               r_hsize_ff <= size_ff;
               if (grow_ff) begin
                  r_src_ff <= ptr_ff;
                  r_len_ff <= hsize_ff;
                  release_ff <= 1'b1;
                  prev_ok_ff <= 1'b0;
                  cur_ff <= (hidx == cls_ff) ? cur_ff : used_head_ff[hidx];
                  state_ff <= S_WALK;
               end else begin
                  state_ff <= S_RESULT;
               end
            end
            S_WALK: state_ff <= S_WALKW;
            S_WALKW: begin
               if (rd.addr == blk_addr) begin
                  if (!release_ff) begin
                     // Block is present: do the allocation, then release.
                     cls_ff <= '0;
                     bsize_ff <= 32'd1 << MIN_CLASS_LOG2;
                     state_ff <= S_MSEARCH;
                  end else begin
                     cur_e_ff <= rd;
                     state_ff <= S_UNLINK;
                  end
               end else if (!rd.link_ok) begin
                  if (grow_ff && release_ff) begin
                     state_ff <= S_RESULT;
                  end else begin
                     r_status_ff <= ST_BADPTR;
                     state_ff <= S_RESULT;
                  end
               end else begin
                  prev_ff <= cur_ff;
                  prev_ok_ff <= 1'b1;
                  cur_ff <= rd.link;
                  state_ff <= S_WALK;
               end
            end
            S_UNLINK: state_ff <= S_UNLINKW;
            S_UNLINKW: begin
               if (!prev_ok_ff) begin
                  used_head_ff[hidx] <= cur_e_ff.link;
                  used_ok_ff[hidx] <= cur_e_ff.link_ok;
               end
               fpush_ff <= 1'b1;
               fpush_idx_ff <= cur_ff;
               fpush_e_ff.addr <= cur_e_ff.addr;
               fpush_e_ff.link <= free_head_ff[hidx];
               fpush_e_ff.link_ok <= free_ok_ff[hidx];
               free_head_ff[hidx] <= cur_ff;
               free_ok_ff[hidx] <= 1'b1;
               state_ff <= S_RESULT;
            end
            S_RESULT: begin
               // The free-list push of a released block uses the write port first.
               if (res_load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
